// ----- hw/rtl/acfp_pkg.sv -----
// Package for the ASCII command frame parser.
// Holds the field widths, character constants, register indexes and the parse phase type.
// It has no dependencies.
package acfp_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;
    localparam int DIGIT_N = 3;

    localparam logic [BYTE_W-1:0] START_RESET   = 8'd38;
    localparam logic [BYTE_W-1:0] END_RESET     = 8'd33;
    localparam logic [WORD_W-1:0] TIMEOUT_RESET = 16'd100;

    localparam logic [BYTE_W-1:0] CHAR_TIME = 8'h74;
    localparam logic [BYTE_W-1:0] CHAR_READ = 8'h72;

    localparam logic [WORD_W-1:0] DIGIT_BIAS = 16'd5328;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic KIND_FRAME   = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        REG_START   = 2'd0,
        REG_END     = 2'd1,
        REG_TIMEOUT = 2'd2,
        REG_NONE    = 2'd3
    } reg_index_t;

    typedef enum logic [8:0] {
        PH_IDLE  = 9'b000000001,
        PH_CMD   = 9'b000000010,
        PH_ADDR0 = 9'b000000100,
        PH_ADDR1 = 9'b000001000,
        PH_ADDR2 = 9'b000010000,
        PH_VAL0  = 9'b000100000,
        PH_VAL1  = 9'b001000000,
        PH_VAL2  = 9'b010000000,
        PH_END   = 9'b100000000
    } phase_t;

    typedef logic [BYTE_W-1:0] digits_t [DIGIT_N];

    function automatic logic [WORD_W-1:0] decode_digits(input digits_t d);
        logic [WORD_W-1:0] sum;
        sum = WORD_W'({8'd0, d[0]} * 16'd100)
            + WORD_W'({8'd0, d[1]} * 16'd10)
            + {8'd0, d[2]};
        return sum - DIGIT_BIAS;
    endfunction

endpackage

// ----- hw/rtl/acfp_item_if.sv -----
// Channel interfaces of the ASCII command frame parser: input items and result items.
// Each carries valid, ready and the payload; widths come from acfp_pkg.
interface acfp_item_if import acfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, command, rx_byte, input ready);
    modport sink (input valid, command, rx_byte, output ready);
endinterface

interface acfp_result_if import acfp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [BYTE_W-1:0]        frame_command;
    logic signed [WORD_W-1:0] address;
    logic signed [WORD_W-1:0] frame_value;

    modport source (output valid, kind, frame_command, address, frame_value, input ready);
    modport sink (input valid, kind, frame_command, address, frame_value, output ready);
endinterface

// ----- hw/rtl/ascii_command_frame_parser.sv -----
// ASCII command frame parser, top level.
// Depends on acfp_pkg and on the channel interfaces in acfp_item_if.sv.
//
// Usage: rx_item carries one transaction per received byte (command 0) or timer tick
// (command 1). Frames are start byte, command byte, three address digits, three value
// digits and end byte; command 't' skips address and value, 'r' skips the value.
// A completed frame or an expired timeout gives one transaction on result.
// The APB port holds start_byte (0x0), end_byte (0x4) and timeout_ticks (0x8).
// Timing: an accepted transaction sits in the input register and its result is loaded
// into the result register when the input register advances, which waits while
// result is stalled; result.valid then rises and the result can be taken.
// One transaction is taken every cycle while result is not stalled; the rate is set
// by the single phase update between the input register and the result register.
// Reset clears the phase, held bytes and timer and loads the register defaults.
// When result is stalled, the input register holds and rx_item.ready falls once it
// is full; nothing is lost or repeated.
module ascii_command_frame_parser import acfp_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    acfp_item_if.sink         rx_item,
    acfp_result_if.source     result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [BYTE_W-1:0] start_byte_reg;
    logic [BYTE_W-1:0] end_byte_reg;
    logic [WORD_W-1:0] timeout_ticks_reg;
    reg_index_t        reg_sel;

    logic              in_valid_reg;
    logic              in_command_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              advance;

    phase_t            phase_reg,      phase_next;
    logic [BYTE_W-1:0] held_cmd_reg,   held_cmd_next;
    digits_t           addr_dig_reg,   addr_dig_next;
    digits_t           val_dig_reg,    val_dig_next;
    logic [WORD_W-1:0] tmo_count_reg,  tmo_count_next;
    logic              tmo_armed_reg,  tmo_armed_next;

    logic              out_valid_reg;
    logic              out_kind_reg,   out_kind_next;
    logic [BYTE_W-1:0] out_cmd_reg,    out_cmd_next;
    logic [WORD_W-1:0] out_addr_reg,   out_addr_next;
    logic [WORD_W-1:0] out_val_reg,    out_val_next;
    logic              emit;

    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[ADDR_W-1:2]);

    always_comb
    begin
        unique case (reg_sel)
            REG_START:   prdata = DATA_W'(start_byte_reg);
            REG_END:     prdata = DATA_W'(end_byte_reg);
            REG_TIMEOUT: prdata = DATA_W'(timeout_ticks_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg    <= START_RESET;
            end_byte_reg      <= END_RESET;
            timeout_ticks_reg <= TIMEOUT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                REG_START:   start_byte_reg    <= pwdata[BYTE_W-1:0];
                REG_END:     end_byte_reg      <= pwdata[BYTE_W-1:0];
                REG_TIMEOUT: timeout_ticks_reg <= pwdata[WORD_W-1:0];
                default:     ;
            endcase
        end
    end

    assign advance       = in_valid_reg && (!out_valid_reg || result.ready);
    assign rx_item.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx_item.ready)
        begin
            in_valid_reg <= rx_item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_item.valid && rx_item.ready)
        begin
            in_command_reg <= rx_item.command;
            in_byte_reg    <= rx_item.rx_byte;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        held_cmd_next  = held_cmd_reg;
        addr_dig_next  = addr_dig_reg;
        val_dig_next   = val_dig_reg;
        tmo_count_next = tmo_count_reg;
        tmo_armed_next = tmo_armed_reg;
        emit           = 1'b0;
        out_kind_next  = KIND_TIMEOUT;
        out_cmd_next   = '0;
        out_addr_next  = '0;
        out_val_next   = '0;

        if (in_command_reg == CMD_TICK)
        begin
            if (tmo_armed_reg)
            begin
                if (tmo_count_reg > 16'd1)
                begin
                    tmo_count_next = tmo_count_reg - 16'd1;
                end
                else
                begin
                    tmo_count_next = '0;
                    tmo_armed_next = 1'b0;
                    phase_next     = PH_IDLE;
                    emit           = 1'b1;
                end
            end
        end
        else
        begin
            if (phase_reg != PH_END)
            begin
                tmo_count_next = timeout_ticks_reg;
                tmo_armed_next = 1'b1;
            end
            unique case (phase_reg)
                PH_IDLE:
                begin
                    held_cmd_next = '0;
                    for (int i = 0; i < DIGIT_N; i++)
                    begin
                        addr_dig_next[i] = '0;
                        val_dig_next[i]  = '0;
                    end
                    if (in_byte_reg == start_byte_reg)
                    begin
                        phase_next = PH_CMD;
                    end
                end
                PH_CMD:
                begin
                    held_cmd_next = in_byte_reg;
                    phase_next    = (in_byte_reg == CHAR_TIME) ? PH_END : PH_ADDR0;
                end
                PH_ADDR0:
                begin
                    addr_dig_next[0] = in_byte_reg;
                    phase_next       = PH_ADDR1;
                end
                PH_ADDR1:
                begin
                    addr_dig_next[1] = in_byte_reg;
                    phase_next       = PH_ADDR2;
                end
                PH_ADDR2:
                begin
                    addr_dig_next[2] = in_byte_reg;
                    phase_next       = (held_cmd_reg == CHAR_READ) ? PH_END : PH_VAL0;
                end
                PH_VAL0:
                begin
                    val_dig_next[0] = in_byte_reg;
                    phase_next      = PH_VAL1;
                end
                PH_VAL1:
                begin
                    val_dig_next[1] = in_byte_reg;
                    phase_next      = PH_VAL2;
                end
                PH_VAL2:
                begin
                    val_dig_next[2] = in_byte_reg;
                    phase_next      = PH_END;
                end
                PH_END:
                begin
                    if (in_byte_reg == end_byte_reg)
                    begin
                        phase_next    = PH_IDLE;
                        emit          = 1'b1;
                        out_kind_next = KIND_FRAME;
                        out_cmd_next  = held_cmd_reg;
                        out_addr_next = decode_digits(addr_dig_reg);
                        out_val_next  = decode_digits(val_dig_reg);
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            held_cmd_reg  <= '0;
            tmo_count_reg <= '0;
            tmo_armed_reg <= 1'b0;
            for (int i = 0; i < DIGIT_N; i++)
            begin
                addr_dig_reg[i] <= '0;
                val_dig_reg[i]  <= '0;
            end
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            held_cmd_reg  <= held_cmd_next;
            addr_dig_reg  <= addr_dig_next;
            val_dig_reg   <= val_dig_next;
            tmo_count_reg <= tmo_count_next;
            tmo_armed_reg <= tmo_armed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_kind_reg <= out_kind_next;
            out_cmd_reg  <= out_cmd_next;
            out_addr_reg <= out_addr_next;
            out_val_reg  <= out_val_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.kind          = out_kind_reg;
    assign result.frame_command = out_cmd_reg;
    assign result.address       = $signed(out_addr_reg);
    assign result.frame_value   = $signed(out_val_reg);

endmodule
